>>> rtl/skl_pkg.sv
`default_nettype none

package skl_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned CAP_W   = 7;
  localparam int unsigned CNT_W   = 7;

  // s_axis payload: func, key, ident, index -> 72 bits, already byte aligned
  localparam int unsigned IN_BITS = FUNC_W + KEY_W + ID_W + IDX_W;
  localparam int unsigned IN_W    = ((IN_BITS + 7) / 8) * 8;

  // m_axis payload: read_key, read_ident, read_valid, smallest_key, kth_key,
  // count, full_res -> 137 bits, padded to 144
  localparam int unsigned OUT_BITS = KEY_W + ID_W + 1 + KEY_W + KEY_W + CNT_W + 1;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                    en;
    logic signed [KEY_W-1:0] key;
    logic [ID_W-1:0]         ident;
  } skl_ins_t;

endpackage

`default_nettype wire

>>> rtl/skl_cell.sv
`default_nettype none

module skl_cell (
  input  logic                             clk_i,
  input  skl_pkg::skl_ins_t                ins_i,
  input  logic                             occ_i,
  input  logic                             prev_hit_i,
  input  logic signed [skl_pkg::KEY_W-1:0] prev_key_i,
  input  logic [skl_pkg::ID_W-1:0]         prev_ident_i,
  output logic                             hit_o,
  output logic signed [skl_pkg::KEY_W-1:0] key_o,
  output logic [skl_pkg::ID_W-1:0]         ident_o
);
  import skl_pkg::*;

  logic signed [KEY_W-1:0] key_q;
  logic [ID_W-1:0]         ident_q;

  // hit: new pair lands here or earlier; list is sorted so hits are monotone
  assign hit_o   = !occ_i || (key_q > ins_i.key);
  assign key_o   = key_q;
  assign ident_o = ident_q;

  always_ff @(posedge clk_i) begin
    if (ins_i.en) begin
      if (prev_hit_i) begin
        key_q   <= prev_key_i;
        ident_q <= prev_ident_i;
      end else if (hit_o) begin
        key_q   <= ins_i.key;
        ident_q <= ins_i.ident;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/smallest_k_sorted_list.sv
`default_nettype none

// Keeps the k smallest (key, ident) pairs in ascending key order in a chain of
// DEPTH cells; every cell compares its key with the incoming key at once and
// either holds, takes the new pair, or takes its upper neighbor's pair. A
// transaction updates the list at the edge it is accepted; its result is
// formed from the updated list and loaded into the output register once that
// register is free. One transaction per cycle is sustained while
// m_axis_tready_i stays high. Equal keys keep arrival order; a key not below
// the k-th key of a full list is dropped. capacity (cfg_wdata_i) of 0 acts as
// 1 and above DEPTH as DEPTH; lowering it cuts the count at once. Write it
// only while no transaction is in flight.
module smallest_k_sorted_list #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [skl_pkg::CAP_W-1:0]   cfg_wdata_i,    // capacity
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // func[1:0], key[33:2], ident[65:34], index[71:66]
  input  logic [skl_pkg::IN_W-1:0]    s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // read_key[31:0], read_ident[63:32], read_valid[64], smallest_key[96:65],
  // kth_key[128:97], count[135:129], full_res[136], zero[143:137]
  output logic [skl_pkg::OUT_W-1:0]   m_axis_tdata_o
);
  import skl_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  function automatic logic [CW-1:0] eff_cap(input logic [CAP_W-1:0] cap);
    logic [CW-1:0] r;
    if (cap == '0) begin
      r = CW'(1);
    end else if (32'(cap) > DEPTH) begin
      r = CW'(DEPTH);
    end else begin
      r = CW'(cap);
    end
    return r;
  endfunction

  logic [CAP_W-1:0] cap_q;
  logic [CW-1:0]    count_q, count_d;
  logic             pend_q;
  logic [IDX_W-1:0] idx_q;
  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  logic [FUNC_W-1:0]       in_func;
  logic signed [KEY_W-1:0] in_key;
  logic [ID_W-1:0]         in_ident;
  logic [IDX_W-1:0]        in_index;

  assign in_func  = s_axis_tdata_i[FUNC_W-1:0];
  assign in_key   = s_axis_tdata_i[FUNC_W +: KEY_W];
  assign in_ident = s_axis_tdata_i[FUNC_W+KEY_W +: ID_W];
  assign in_index = s_axis_tdata_i[FUNC_W+KEY_W+ID_W +: IDX_W];

  logic          out_free;
  logic          in_acc;
  logic [CW-1:0] lim, lim_m1, cfg_lim;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !pend_q || out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign lim             = eff_cap(cap_q);
  assign lim_m1          = lim - CW'(1);
  assign cfg_lim         = eff_cap(cfg_wdata_i);

  // cell chain
  logic                    hit   [DEPTH];
  logic signed [KEY_W-1:0] ckey  [DEPTH];
  logic [ID_W-1:0]         cid   [DEPTH];
  skl_ins_t                ins;
  logic                    room;

  always_comb begin
    room = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CW'(i) == lim_m1) begin
        room = hit[i];
      end
    end
  end

  assign ins.en    = in_acc && (in_func == FUNC_INSERT) && room;
  assign ins.key   = in_key;
  assign ins.ident = in_ident;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                    p_hit;
    logic signed [KEY_W-1:0] p_key;
    logic [ID_W-1:0]         p_id;
    if (g == 0) begin : g_head
      assign p_hit = 1'b0;
      assign p_key = KEY_MAX;
      assign p_id  = '0;
    end else begin : g_link
      assign p_hit = hit[g-1];
      assign p_key = ckey[g-1];
      assign p_id  = cid[g-1];
    end
    skl_cell u_cell (
      .clk_i        (clk_i),
      .ins_i        (ins),
      .occ_i        (count_q > CW'(g)),
      .prev_hit_i   (p_hit),
      .prev_key_i   (p_key),
      .prev_ident_i (p_id),
      .hit_o        (hit[g]),
      .key_o        (ckey[g]),
      .ident_o      (cid[g])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cfg_we_i) begin
      count_d = (count_q > cfg_lim) ? cfg_lim : count_q;
    end else if (in_acc) begin
      case (in_func)
        FUNC_INSERT: begin
          if (room && (count_q < lim)) begin
            count_d = count_q + CW'(1);
          end
        end
        FUNC_CLEAR: count_d = '0;
        default:    count_d = count_q;
      endcase
    end
  end

  // result of the pending transaction, taken from the updated list
  logic signed [KEY_W-1:0] r_key, r_small, r_kth, sel_key, sel_kth;
  logic [ID_W-1:0]         r_id, sel_id;
  logic                    r_valid, r_full;

  always_comb begin
    sel_key = KEY_MAX;
    sel_id  = '0;
    sel_kth = KEY_MAX;
    for (int i = 0; i < DEPTH; i++) begin
      if (32'(idx_q) == i) begin
        sel_key = ckey[i];
        sel_id  = cid[i];
      end
      if (CW'(i) == lim_m1) begin
        sel_kth = ckey[i];
      end
    end
    r_valid = 32'(idx_q) < 32'(count_q);
    r_full  = count_q >= lim;
    r_key   = r_valid ? sel_key : KEY_MAX;
    r_id    = r_valid ? sel_id : '0;
    r_small = (count_q != '0) ? ckey[0] : KEY_MAX;
    r_kth   = r_full ? sel_kth : KEY_MAX;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (pend_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s_axis_tready_o) begin
        pend_q <= s_axis_tvalid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q <= in_index;
    end
    if (pend_q && out_free) begin
      out_data_q <= {(OUT_W - OUT_BITS)'(0), r_full, CNT_W'(count_q), r_kth, r_small,
                     r_valid, r_id, r_key};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

>>> rtl/skl_checker.sv
`default_nettype none

module skl_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [skl_pkg::OUT_W-1:0]   m_axis_tdata_o
);
  import skl_pkg::*;

  logic signed [KEY_W-1:0] rd_key, small_key, kth_key;
  logic [ID_W-1:0]         rd_id;
  logic                    rd_valid, full;
  logic [CNT_W-1:0]        cnt;

  assign rd_key    = m_axis_tdata_o[31:0];
  assign rd_id     = m_axis_tdata_o[63:32];
  assign rd_valid  = m_axis_tdata_o[64];
  assign small_key = m_axis_tdata_o[96:65];
  assign kth_key   = m_axis_tdata_o[128:97];
  assign cnt       = m_axis_tdata_o[135:129];
  assign full      = m_axis_tdata_o[136];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result transaction dropped while stalled");

  a_unfilled_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !rd_valid |-> (rd_key == KEY_MAX) && (rd_id == '0))
    else $error("unfilled rank reported data");

  a_kth_sentinel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !full |-> kth_key == KEY_MAX)
    else $error("kth key set on a list that is not full");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (cnt == '0) |-> (small_key == KEY_MAX) && !rd_valid)
    else $error("empty list reported an entry");

endmodule

bind smallest_k_sorted_list skl_checker u_skl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire

>>> sim/tb_smallest_k_sorted_list.sv
`timescale 1ns / 100ps

module tb_smallest_k_sorted_list;
  import skl_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam int unsigned LIST_DEPTH = 64;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned ITEMS_PER_PHASE = 140;

  typedef struct {
    logic [KEY_W-1:0] read_key;
    logic [ID_W-1:0]  read_ident;
    logic             read_valid;
    logic [KEY_W-1:0] smallest_key;
    logic [KEY_W-1:0] kth_key;
    logic [CNT_W-1:0] count;
    logic             full_res;
  } list_report_t;

  class kbest_scoreboard;
    logic signed [KEY_W-1:0] keys[LIST_DEPTH];
    logic [ID_W-1:0]         idents[LIST_DEPTH];
    int unsigned             n_held;
    logic [CAP_W-1:0]        capacity;
    list_report_t            expected_reports[$];
    int unsigned             errors;

    function new();
      n_held   = 0;
      capacity = CAP_RESET;
      errors   = 0;
    endfunction

    function int unsigned k_limit();
      if (capacity == 0) return 1;
      if (capacity > LIST_DEPTH) return LIST_DEPTH;
      return capacity;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity = value;
      if (n_held > k_limit()) n_held = k_limit();
    endfunction

    // apply one accepted transaction to the list and queue the report it produces
    function void note_op(logic [FUNC_W-1:0] func, logic signed [KEY_W-1:0] key,
                          logic [ID_W-1:0] ident, logic [IDX_W-1:0] index);
      list_report_t rep;
      int unsigned  lim;
      int unsigned  pos;
      int unsigned  last;
      lim = k_limit();
      if (func == FUNC_INSERT) begin
        pos = 0;
        while (pos < n_held && keys[pos] <= key) pos++;
        if (pos < lim) begin
          last = (n_held < lim) ? n_held : lim - 1;
          for (int unsigned i = last; i > pos; i--) begin
            keys[i]   = keys[i-1];
            idents[i] = idents[i-1];
          end
          keys[pos]   = key;
          idents[pos] = ident;
          if (n_held < lim) n_held++;
        end
      end else if (func == FUNC_CLEAR) begin
        n_held = 0;
      end
      rep.read_key     = KEY_MAX;
      rep.read_ident   = '0;
      rep.read_valid   = 1'b0;
      rep.smallest_key = KEY_MAX;
      rep.kth_key      = KEY_MAX;
      rep.count        = CNT_W'(n_held);
      rep.full_res     = (n_held >= lim);
      if (index < n_held) begin
        rep.read_key   = keys[index];
        rep.read_ident = idents[index];
        rep.read_valid = 1'b1;
      end
      if (n_held > 0) rep.smallest_key = keys[0];
      if (rep.full_res) rep.kth_key = keys[lim-1];
      expected_reports.push_back(rep);
    endfunction

    function bit differs(string field, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
      if (want === got) return 1'b0;
      $error("%s: expected %h, got %h", field, want, got);
      return 1'b1;
    endfunction

    function void check_report(logic [OUT_W-1:0] d);
      list_report_t want;
      bit           bad;
      if (expected_reports.size() == 0) begin
        errors++;
        $error("result transaction with no input pending");
        return;
      end
      want = expected_reports.pop_front();
      bad = 1'b0;
      bad |= differs("read_key", want.read_key, d[31:0]);
      bad |= differs("read_ident", want.read_ident, d[63:32]);
      bad |= differs("read_valid", want.read_valid, d[64]);
      bad |= differs("smallest_key", want.smallest_key, d[96:65]);
      bad |= differs("kth_key", want.kth_key, d[128:97]);
      bad |= differs("count", want.count, d[135:129]);
      bad |= differs("full_res", want.full_res, d[136]);
      if (bad) errors++;
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  logic             s_valid = 1'b0;
  logic [IN_W-1:0]  s_data = '0;
  logic             s_ready;
  logic             m_valid;
  logic             m_ready = 1'b0;
  logic [OUT_W-1:0] m_data;

  kbest_scoreboard sb = new();
  bit              no_idle = 1'b0;
  bit              hold_req = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  smallest_k_sorted_list u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  // receiver: checks results, stalls at random, and holds off for a long stretch on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_valid && m_ready) sb.check_report(m_data);
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = RX_HOLD_CYCLES;
        m_ready <= 1'b0;
      end else begin
        m_ready <= no_idle || ($urandom_range(99) >= 16);
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    int unsigned quiet;
    if (!rst_ni || (s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
    else quiet++;
    if (quiet == STALL_LIMIT) begin
      $display("smallest_k_sorted_list: mismatch");
      $finish;
    end
  end

  task automatic send_item(logic [FUNC_W-1:0] func, logic signed [KEY_W-1:0] key,
                           logic [ID_W-1:0] ident, logic [IDX_W-1:0] index);
    while (!no_idle && $urandom_range(99) < 16) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {index, ident, key, func};
    do @(posedge clk_i); while (!s_ready);
    sb.note_op(func, key, ident, index);
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] value);
    wait_drained();
    // let the pipeline settle before touching the register
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    sb.set_capacity(value);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned             caps[13];
    int unsigned             r;
    logic [FUNC_W-1:0]       f;
    logic signed [KEY_W-1:0] k;
    logic [IDX_W-1:0]        ix;

    caps = '{127, 64, 1, 5, 17, 64, 40, 2, 0, 100, 64, 63, 9};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list, unused opcode, extremes, equal keys keep arrival order
    send_item(FUNC_READ, 0, 0, 0);
    send_item(FUNC_NOP, 0, 0, 0);
    send_item(FUNC_INSERT, KEY_MAX, 32'hFFFF_FFFF, 0);
    send_item(FUNC_INSERT, KEY_MIN, 0, 1);
    send_item(FUNC_INSERT, 0, 1, 63);
    send_item(FUNC_INSERT, 0, 2, 2);
    send_item(FUNC_READ, 0, 0, 1);
    send_item(FUNC_READ, 0, 0, 3);
    send_item(FUNC_READ, 0, 0, 4);
    send_item(FUNC_READ, 0, 0, 63);
    send_item(FUNC_NOP, 1, 1, 1);
    send_item(FUNC_CLEAR, 0, 0, 0);

    // tiny list: drop on full when key not below k-th
    set_capacity(2);
    send_item(FUNC_INSERT, 5, 10, 0);
    send_item(FUNC_INSERT, 3, 11, 1);
    send_item(FUNC_INSERT, 4, 12, 1);
    send_item(FUNC_INSERT, 4, 13, 1);
    send_item(FUNC_INSERT, 10, 14, 0);
    send_item(FUNC_INSERT, 1, 15, 1);
    send_item(FUNC_READ, 0, 0, 2);

    // zero acts as one and cuts the count
    set_capacity(0);
    send_item(FUNC_READ, 0, 0, 0);
    send_item(FUNC_INSERT, -5, 16, 0);
    send_item(FUNC_INSERT, -5, 17, 0);
    send_item(FUNC_READ, 0, 0, 1);

    for (int p = 0; p < 13; p++) begin
      if (p % 3 == 0) send_item(FUNC_CLEAR, 0, 0, 0);
      set_capacity(caps[p]);
      no_idle = (p == 4);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 1 && i == 30) hold_req = 1'b1;
        if (p == 6 && i == 70) wait_drained();
        r = $urandom_range(99);
        f = (r < 1) ? FUNC_CLEAR : (r < 16) ? FUNC_READ : (r < 18) ? FUNC_NOP : FUNC_INSERT;
        case ($urandom_range(9))
          0, 1, 2, 3, 4: k = $urandom;
          5, 6, 7:       k = $signed($urandom_range(40)) - 20;
          8: begin
            case ($urandom_range(3))
              0:       k = KEY_MAX;
              1:       k = KEY_MIN;
              2:       k = 0;
              default: k = -1;
            endcase
          end
          default:       k = $urandom_range(1) ? KEY_MAX - $urandom_range(3)
                                               : KEY_MIN + $urandom_range(3);
        endcase
        // bias reads toward filled ranks
        if ($urandom_range(1)) ix = IDX_W'($urandom_range(63));
        else ix = IDX_W'($urandom_range(sb.n_held > 63 ? 63 : sb.n_held));
        send_item(f, k, $urandom, ix);
      end
    end

    no_idle = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("smallest_k_sorted_list: match");
    end else begin
      $display("smallest_k_sorted_list: mismatch");
    end
    $finish;
  end

endmodule

>>> smallest_k_sorted_list.f
rtl/skl_pkg.sv
rtl/skl_cell.sv
rtl/smallest_k_sorted_list.sv
rtl/skl_checker.sv
sim/tb_smallest_k_sorted_list.sv
